[rtl/core/cds_pkg.sv]
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, codes and constants of the calendar date shift block:
// control word layout, datapath commands, jump conditions and date constants.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int YearW  = 16;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int ShiftW = 21;
  localparam int WalkW  = 22;
  localparam int OpW    = 2;
  localparam int StepW  = 3;
  localparam int ProdW  = 28;
  localparam int QuotW  = 12;
  localparam int RecipShift = 16;

  localparam logic [OpW-1:0] OP_LOAD    = 2'd0;
  localparam logic [OpW-1:0] OP_SHIFT   = 2'd1;
  localparam logic [OpW-1:0] OP_COMPARE = 2'd2;

  localparam logic signed [YearW-1:0] ResetYear  = 16'sd2021;
  localparam logic [MonthW-1:0]       ResetMonth = 4'd3;
  localparam logic [DayW-1:0]         ResetDay   = 5'd26;

  localparam logic signed [YearW-1:0] YearMax = 16'sh7fff;
  localparam logic signed [YearW-1:0] YearMin = 16'sh8000;

  // year mod 25 by reciprocal: floor(2^16 / 25), then one correction
  localparam logic [QuotW-1:0] Recip25 = 12'd2621;
  localparam int Mod25 = 25;
  // 2^16 mod 25 is 11, so a negative year adds 25 - 11
  localparam int NegFold = 14;

  localparam logic [StepW-1:0] STEP_FETCH    = 3'd0;
  localparam logic [StepW-1:0] STEP_DISPATCH = 3'd1;
  localparam logic [StepW-1:0] STEP_EXEC     = 3'd2;
  localparam logic [StepW-1:0] STEP_MUL      = 3'd3;
  localparam logic [StepW-1:0] STEP_MOD      = 3'd4;
  localparam logic [StepW-1:0] STEP_FOLD     = 3'd5;
  localparam logic [StepW-1:0] STEP_WALK     = 3'd6;
  localparam logic [StepW-1:0] STEP_COMMIT   = 3'd7;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LATCH,
    DP_EXEC,
    DP_MUL,
    DP_MOD,
    DP_FOLD,
    DP_WALK,
    DP_COMMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_OP_SHIFT,
    COND_WALK_BUSY
  } cond_t;

  typedef struct packed {
    dp_op_t           dp_op;
    cond_t            cond;
    logic             emit;
    logic [StepW-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic op_shift;
    logic walk_busy;
  } dp_status_t;

endpackage

[rtl/core/calendar_date_shift.sv]
// ----------------------------------------------------------------------------
// calendar_date_shift
// Holds one signed-year calendar date; loads, shifts by a day count or
// compares it, one result per transfer, under a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Load, compare and the unused op step through fetch, dispatch and execute.
// A shift steps through fetch, dispatch, multiply, mod, fold, walk and
// commit; the multiply, mod and fold steps work out the year mod 25 for the
// leap rule, then the walk step renormalizes the day by one month per cycle.
// The next item is taken as soon as the result sits in the output register;
// the sequencer only waits when a new result meets an untaken one.
module calendar_date_shift (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cds_pkg::OpW-1:0]           op,
  input  logic signed [cds_pkg::YearW-1:0]  in_year,
  input  logic [cds_pkg::MonthW-1:0]        in_month,
  input  logic [cds_pkg::DayW-1:0]          in_day,
  input  logic signed [cds_pkg::ShiftW-1:0] shift_days,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cds_pkg::YearW-1:0]  out_year,
  output logic [cds_pkg::MonthW-1:0]        out_month,
  output logic [cds_pkg::DayW-1:0]          out_day,
  output logic                              is_greater,
  output logic                              is_equal,
  output logic                              is_less,
  output logic                              overflow
);

  logic [cds_pkg::StepW-1:0] step;
  logic [cds_pkg::StepW-1:0] step_next;
  cds_pkg::ctrl_word_t       word;
  cds_pkg::dp_status_t       status;
  cds_pkg::dp_op_t           dp_cmd;
  logic                      in_xfer;
  logic                      stall;
  logic                      jump;

  cds_ucode_rom u_rom (
    .step (step),
    .word (word)
  );

  cds_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .op         (op),
    .in_year    (in_year),
    .in_month   (in_month),
    .in_day     (in_day),
    .shift_days (shift_days),
    .status     (status),
    .out_year   (out_year),
    .out_month  (out_month),
    .out_day    (out_day),
    .is_greater (is_greater),
    .is_equal   (is_equal),
    .is_less    (is_less),
    .overflow   (overflow)
  );

  always_comb begin
    in_ready = (word.dp_op == cds_pkg::DP_LATCH) && !rst;
    in_xfer  = in_valid && in_ready;
    stall    = word.emit && out_valid && !out_ready;
    case (word.cond)
      cds_pkg::COND_NEXT:      jump = 1'b0;
      cds_pkg::COND_ALWAYS:    jump = 1'b1;
      cds_pkg::COND_NO_INPUT:  jump = !in_valid;
      cds_pkg::COND_OP_SHIFT:  jump = status.op_shift;
      cds_pkg::COND_WALK_BUSY: jump = status.walk_busy;
      default:                 jump = 1'b0;
    endcase
    if (stall) begin
      step_next = step;
    end else if (jump) begin
      step_next = word.target;
    end else begin
      step_next = step + 1'b1;
    end
    if (stall || (word.dp_op == cds_pkg::DP_LATCH && !in_xfer)) begin
      dp_cmd = cds_pkg::DP_NOP;
    end else begin
      dp_cmd = word.dp_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= cds_pkg::STEP_FETCH;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (word.emit && !stall) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // a taken item keeps the input side closed while it is worked on
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // at most one of the compare and overflow flags per result
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({is_greater, is_equal, is_less, overflow}))
    else $error("conflicting result flags");

  // a result held for a stalled sink keeps its date
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_year) &&
                                   $stable(out_month) && $stable(out_day)))
    else $error("result changed while stalled");
`endif

endmodule

[rtl/core/cds_ucode_rom.sv]
// ----------------------------------------------------------------------------
// cds_ucode_rom
// Control store of the sequencer: one control word per program step.
// ----------------------------------------------------------------------------
module cds_ucode_rom (
  input  logic [cds_pkg::StepW-1:0] step,
  output cds_pkg::ctrl_word_t       word
);

  always_comb begin
    case (step)
      cds_pkg::STEP_FETCH: begin
        word = '{cds_pkg::DP_LATCH, cds_pkg::COND_NO_INPUT, 1'b0, cds_pkg::STEP_FETCH};
      end
      cds_pkg::STEP_DISPATCH: begin
        word = '{cds_pkg::DP_NOP, cds_pkg::COND_OP_SHIFT, 1'b0, cds_pkg::STEP_MUL};
      end
      cds_pkg::STEP_EXEC: begin
        word = '{cds_pkg::DP_EXEC, cds_pkg::COND_ALWAYS, 1'b1, cds_pkg::STEP_FETCH};
      end
      cds_pkg::STEP_MUL: begin
        word = '{cds_pkg::DP_MUL, cds_pkg::COND_NEXT, 1'b0, cds_pkg::STEP_FETCH};
      end
      cds_pkg::STEP_MOD: begin
        word = '{cds_pkg::DP_MOD, cds_pkg::COND_NEXT, 1'b0, cds_pkg::STEP_FETCH};
      end
      cds_pkg::STEP_FOLD: begin
        word = '{cds_pkg::DP_FOLD, cds_pkg::COND_NEXT, 1'b0, cds_pkg::STEP_FETCH};
      end
      cds_pkg::STEP_WALK: begin
        word = '{cds_pkg::DP_WALK, cds_pkg::COND_WALK_BUSY, 1'b0, cds_pkg::STEP_WALK};
      end
      cds_pkg::STEP_COMMIT: begin
        word = '{cds_pkg::DP_COMMIT, cds_pkg::COND_ALWAYS, 1'b1, cds_pkg::STEP_FETCH};
      end
      default: begin
        word = '{cds_pkg::DP_LATCH, cds_pkg::COND_NO_INPUT, 1'b0, cds_pkg::STEP_FETCH};
      end
    endcase
  end

endmodule

[rtl/core/cds_datapath.sv]
// ----------------------------------------------------------------------------
// cds_datapath
// Stored date, input latch, year mod 25 unit, month walk and result register,
// each action selected by the command from the sequencer.
// ----------------------------------------------------------------------------
module cds_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cds_pkg::dp_op_t                     dp_cmd,
  input  logic [cds_pkg::OpW-1:0]             op,
  input  logic signed [cds_pkg::YearW-1:0]    in_year,
  input  logic [cds_pkg::MonthW-1:0]          in_month,
  input  logic [cds_pkg::DayW-1:0]            in_day,
  input  logic signed [cds_pkg::ShiftW-1:0]   shift_days,
  output cds_pkg::dp_status_t                 status,
  output logic signed [cds_pkg::YearW-1:0]    out_year,
  output logic [cds_pkg::MonthW-1:0]          out_month,
  output logic [cds_pkg::DayW-1:0]            out_day,
  output logic                                is_greater,
  output logic                                is_equal,
  output logic                                is_less,
  output logic                                overflow
);

  logic [cds_pkg::OpW-1:0]           op_r;
  logic signed [cds_pkg::YearW-1:0]  iy_r;
  logic [cds_pkg::MonthW-1:0]        im_r;
  logic [cds_pkg::DayW-1:0]          id_r;
  logic signed [cds_pkg::ShiftW-1:0] sd_r;

  logic signed [cds_pkg::YearW-1:0]  cur_year;
  logic [cds_pkg::MonthW-1:0]        cur_month;
  logic [cds_pkg::DayW-1:0]          cur_day;

  logic signed [cds_pkg::YearW-1:0]  wy;
  logic [cds_pkg::MonthW-1:0]        wm;
  logic signed [cds_pkg::WalkW-1:0]  wd;
  logic [cds_pkg::ProdW-1:0]         prod;
  logic [5:0]                        rem;
  logic [4:0]                        m25;
  logic                              ovf;

  logic [cds_pkg::QuotW-1:0]         quot;
  logic [cds_pkg::YearW:0]           q25;
  logic [cds_pkg::YearW:0]           rem_full;
  logic [4:0]                        rem_lo;
  logic [5:0]                        fold_sum;
  logic [4:0]                        fold_res;

  logic                              leap;
  logic [4:0]                        len_cur;
  logic [4:0]                        len_prev;
  logic                              fwd_go;
  logic                              bwd_go;
  logic                              wrap_f;
  logic                              wrap_b;
  logic [cds_pkg::MonthW-1:0]        m_fwd;
  logic [cds_pkg::MonthW-1:0]        m_bwd;
  logic signed [cds_pkg::YearW-1:0]  y_fwd;
  logic signed [cds_pkg::YearW-1:0]  y_bwd;
  logic [5:0]                        m25_fsum;
  logic [4:0]                        m25_fwd;
  logic signed [6:0]                 m25_bdiff;
  logic [4:0]                        m25_bwd;
  logic                              step_ovf;

  logic                              cmp_gt;
  logic                              cmp_eq;
  logic                              is_cmp;
  logic signed [cds_pkg::YearW-1:0]  ex_year;
  logic [cds_pkg::MonthW-1:0]        ex_month;
  logic [cds_pkg::DayW-1:0]          ex_day;

  function automatic logic [4:0] month_len(input logic [cds_pkg::MonthW-1:0] m,
                                           input logic lp);
    logic [4:0] len;
    begin
      if (m == 4'd2) begin
        len = lp ? 5'd29 : 5'd28;
      end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
        len = 5'd30;
      end else begin
        len = 5'd31;
      end
      return len;
    end
  endfunction

  // year mod 25 from the registered reciprocal product
  always_comb begin
    quot     = prod[cds_pkg::RecipShift +: cds_pkg::QuotW];
    q25      = {5'b0, quot} * 17'(cds_pkg::Mod25);
    rem_full = {1'b0, cur_year} - q25;
    rem_lo   = (rem >= 6'(cds_pkg::Mod25)) ? 5'(rem - 6'(cds_pkg::Mod25)) : rem[4:0];
    fold_sum = {1'b0, rem_lo} + (cur_year[cds_pkg::YearW-1] ? 6'(cds_pkg::NegFold) : 6'd0);
    fold_res = (fold_sum >= 6'(cds_pkg::Mod25)) ? 5'(fold_sum - 6'(cds_pkg::Mod25))
                                                : fold_sum[4:0];
  end

  // one month step of the walk
  always_comb begin
    leap     = (wy[1:0] == 2'd0) && ((m25 != 5'd0) || (wy[3:0] == 4'd0));
    len_cur  = month_len(wm, leap);
    fwd_go   = wd > $signed({17'b0, len_cur});
    bwd_go   = wd < 22'sd1;
    wrap_f   = wm >= 4'd12;
    wrap_b   = wm <= 4'd1;
    m_fwd    = wrap_f ? 4'd1 : wm + 4'd1;
    m_bwd    = wrap_b ? 4'd12 : wm - 4'd1;
    len_prev = wrap_b ? 5'd31 : month_len(m_bwd, leap);
    y_fwd    = (wy == -16'sd1) ? 16'sd1 : wy + 16'sd1;
    y_bwd    = (wy == 16'sd1) ? -16'sd1 : wy - 16'sd1;
    m25_fsum = {1'b0, m25} + ((wy == -16'sd1) ? 6'd2 : 6'd1);
    m25_fwd  = (m25_fsum >= 6'(cds_pkg::Mod25)) ? 5'(m25_fsum - 6'(cds_pkg::Mod25))
                                                : m25_fsum[4:0];
    m25_bdiff = $signed({2'b0, m25}) - ((wy == 16'sd1) ? 7'sd2 : 7'sd1);
    m25_bwd  = (m25_bdiff < 7'sd0) ? 5'(m25_bdiff + 7'(cds_pkg::Mod25)) : m25_bdiff[4:0];
    step_ovf = (fwd_go && wrap_f && (wy == cds_pkg::YearMax)) ||
               (bwd_go && wrap_b && (wy == cds_pkg::YearMin));
    status.walk_busy = (fwd_go || bwd_go) && !step_ovf;
    status.op_shift  = op_r == cds_pkg::OP_SHIFT;
  end

  always_comb begin
    cmp_gt = 1'b0;
    cmp_eq = 1'b0;
    if (cur_year != iy_r) begin
      cmp_gt = cur_year > iy_r;
    end else if (cur_month != im_r) begin
      cmp_gt = cur_month > im_r;
    end else if (cur_day != id_r) begin
      cmp_gt = cur_day > id_r;
    end else begin
      cmp_eq = 1'b1;
    end
    is_cmp   = op_r == cds_pkg::OP_COMPARE;
    ex_year  = (op_r == cds_pkg::OP_LOAD) ? iy_r : cur_year;
    ex_month = (op_r == cds_pkg::OP_LOAD) ? im_r : cur_month;
    ex_day   = (op_r == cds_pkg::OP_LOAD) ? id_r : cur_day;
  end

  // stored date
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year  <= cds_pkg::ResetYear;
      cur_month <= cds_pkg::ResetMonth;
      cur_day   <= cds_pkg::ResetDay;
    end else if (dp_cmd == cds_pkg::DP_EXEC && op_r == cds_pkg::OP_LOAD) begin
      cur_year  <= iy_r;
      cur_month <= im_r;
      cur_day   <= id_r;
    end else if (dp_cmd == cds_pkg::DP_COMMIT && !ovf) begin
      cur_year  <= wy;
      cur_month <= wm;
      cur_day   <= wd[cds_pkg::DayW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (dp_cmd)
      cds_pkg::DP_LATCH: begin
        op_r <= op;
        iy_r <= in_year;
        im_r <= in_month;
        id_r <= in_day;
        sd_r <= shift_days;
      end
      cds_pkg::DP_EXEC: begin
        out_year   <= ex_year;
        out_month  <= ex_month;
        out_day    <= ex_day;
        is_greater <= is_cmp && cmp_gt;
        is_equal   <= is_cmp && cmp_eq;
        is_less    <= is_cmp && !cmp_gt && !cmp_eq;
        overflow   <= 1'b0;
      end
      cds_pkg::DP_MUL: begin
        prod <= {12'b0, cur_year} * {16'b0, cds_pkg::Recip25};
        wy   <= cur_year;
        wm   <= cur_month;
        wd   <= $signed({17'b0, cur_day}) + cds_pkg::WalkW'(sd_r);
        ovf  <= 1'b0;
      end
      cds_pkg::DP_MOD: begin
        rem <= rem_full[5:0];
      end
      cds_pkg::DP_FOLD: begin
        m25 <= fold_res;
      end
      cds_pkg::DP_WALK: begin
        if (step_ovf) begin
          ovf <= 1'b1;
        end else if (fwd_go) begin
          wd <= wd - $signed({17'b0, len_cur});
          wm <= m_fwd;
          if (wrap_f) begin
            wy  <= y_fwd;
            m25 <= m25_fwd;
          end
        end else if (bwd_go) begin
          wd <= wd + $signed({17'b0, len_prev});
          wm <= m_bwd;
          if (wrap_b) begin
            wy  <= y_bwd;
            m25 <= m25_bwd;
          end
        end
      end
      cds_pkg::DP_COMMIT: begin
        out_year   <= ovf ? cur_year : wy;
        out_month  <= ovf ? cur_month : wm;
        out_day    <= ovf ? cur_day : wd[cds_pkg::DayW-1:0];
        is_greater <= 1'b0;
        is_equal   <= 1'b0;
        is_less    <= 1'b0;
        overflow   <= ovf;
      end
      default: begin
      end
    endcase
  end

endmodule
